// ----- hw/rtl/cbz_pkg.sv -----
// shared constants, types and helpers of the cubic bezier timing evaluator
`default_nettype none
package cbz_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int ONE_Q            = 1 << FRAC_BITS;
    localparam int SAMPLE_COUNT_DEF = 11;
    localparam int NEWTON_STEPS     = 4;

    localparam int T_W    = FRAC_BITS + 1;
    localparam int COEF_W = 36;
    localparam int ACC_W  = 40;
    localparam int DIV_NW = 52;
    localparam int DIV_DW = ACC_W;
    localparam int DIV_QW = DIV_NW + 1;
    localparam int NS_W   = $clog2(NEWTON_STEPS + 1);
    localparam int BIS_W  = $clog2(FRAC_BITS + 2);
    localparam int APB_AW = 4;

    localparam logic [T_W-1:0] ONE_T = T_W'(ONE_Q);
    localparam longint I32_MAX_L = 64'sh7fff_ffff;
    localparam longint I32_MIN_L = -64'sh8000_0000;

    typedef enum logic [1:0] {
        REG_P1X,
        REG_P1Y,
        REG_P2X,
        REG_P2Y
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_TINIT,
        ST_TWR,
        ST_IDLE,
        ST_SRCH,
        ST_INTM,
        ST_INTD,
        ST_INTW,
        ST_EVAL,
        ST_NXR,
        ST_NDR,
        ST_NDW,
        ST_BIS,
        ST_BISR,
        ST_FIN,
        ST_FY,
        ST_FDX,
        ST_FDY,
        ST_FW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic signed [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIV_QW-1:0] quot;
    } div_rsp_t;

    function automatic logic [T_W-1:0] clamp_t(input logic signed [DIV_QW:0] v);
        logic [T_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > signed'((DIV_QW+1)'(ONE_Q))) begin
            r = ONE_T;
        end else begin
            r = v[T_W-1:0];
        end
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [DIV_QW-1:0] v);
        return (v > signed'(DIV_QW'(I32_MAX_L))) || (v < signed'(DIV_QW'(I32_MIN_L)));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [DIV_QW-1:0] v);
        logic [31:0] r;
        if (v > signed'(DIV_QW'(I32_MAX_L))) begin
            r = 32'h7fff_ffff;
        end else if (v < signed'(DIV_QW'(I32_MIN_L))) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cubic_bezier_timing_eval.sv -----
// top level of the cubic bezier timing curve evaluator
//
//  channel | dir | beat payload
//  s_      | in  | tdata: progress_x
//  m_      | out | tdata: curve_y, curve_slope; tuser: slope_saturated
//  apb     | in  | control points p1x, p1y, p2x, p2y
//
// the time an item takes from the accepted beat to m_tvalid is set by the divider
// (one quotient each for table interpolation, each newton step and the slope) and the
// shared multiplier (curve values, up to 17 bisection steps)
// after reset and after each register write the sample table is rebuilt, with
// s_tready low
// a new beat is taken while a finished result waits on m_
`default_nettype none
module cubic_bezier_timing_eval #(
    parameter int SAMPLE_COUNT = cbz_pkg::SAMPLE_COUNT_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [31:0]                  s_tdata,   // [31:0] progress_x
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [63:0]                  m_tdata,   // [31:0] curve_y, [63:32] curve_slope
    output logic [0:0]                   m_tuser,   // [0] slope_saturated
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [cbz_pkg::APB_AW-1:0]   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int FB     = cbz_pkg::FRAC_BITS;
    localparam int T_W    = cbz_pkg::T_W;
    localparam int ACC_W  = cbz_pkg::ACC_W;
    localparam int COEF_W = cbz_pkg::COEF_W;
    localparam int QW     = cbz_pkg::DIV_QW;
    localparam int NW     = cbz_pkg::DIV_NW;
    localparam int DW     = cbz_pkg::DIV_DW;
    localparam int NS_W   = cbz_pkg::NS_W;
    localparam int BIS_W  = cbz_pkg::BIS_W;
    localparam int IW     = $clog2(SAMPLE_COUNT);
    localparam int RW     = $clog2(SAMPLE_COUNT);
    localparam int STEP_Q = cbz_pkg::ONE_Q / (SAMPLE_COUNT - 1);
    localparam int STEP_R = cbz_pkg::ONE_Q % (SAMPLE_COUNT - 1);
    localparam int PROD_W = ACC_W + T_W + 1;
    localparam logic [T_W-1:0] ONE_T = cbz_pkg::ONE_T;

    // configuration
    logic [16:0]        p1x_reg, p2x_reg;
    logic signed [27:0] p1y_reg, p2y_reg;
    logic               cfg_wr;
    cbz_pkg::reg_idx_t  cfg_idx;

    // coefficients
    logic [T_W-1:0]           p1x_c, p2x_c;
    logic signed [COEF_W-1:0] ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    logic signed [COEF_W-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;

    // sequencer state
    cbz_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [1:0]      ev_k_reg, ev_k_next;
    logic            ev_y_reg, ev_y_next, ev_d_reg, ev_d_next;
    logic            ev_last;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] x2_reg, x2_next, dx_reg, dx_next;
    logic [IW-1:0]           i_reg, i_next;
    logic [T_W-1:0]          gq_reg, gq_next, gprev_reg, gprev_next;
    logic [RW-1:0]           gr_reg, gr_next;
    logic [T_W-1:0]          x_reg, x_next, prev_reg, prev_next, span_reg, span_next;
    logic [T_W-1:0]          t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [NS_W-1:0]         n_reg, n_next;
    logic [BIS_W-1:0]        b_reg, b_next;
    logic [31:0]             y_reg, y_next, slope_reg, slope_next;
    logic                    sat_reg, sat_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic [T_W-1:0] tbl_reg [SAMPLE_COUNT];
    logic           tbl_we;
    logic [T_W-1:0] tbl_wd, tbl_cur;

    // shared multiplier
    logic signed [ACC_W-1:0]  mul_a, mul_add, a_sel, b_sel, c_sel, start_coef, add0;
    logic signed [T_W:0]      mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  mul_sh, mul_res;

    // grid stepping
    logic [T_W-1:0] gq_adv;
    logic [RW-1:0]  gr_adv;
    logic [RW:0]    rsum;

    // helpers
    logic signed [31:0]      s_x;
    logic [T_W-1:0]          x_in, x_diff, t_mid_lo, t_mid_hi;
    logic signed [ACC_W-1:0] x_ext, xres;
    logic signed [QW:0]      q_w, t0_w, t2_w;
    logic [T_W:0]            t_sum;
    logic [T_W-1:0]          acc_clamp;

    cbz_pkg::div_req_t div_req;
    cbz_pkg::div_rsp_t div_rsp;

    cbz_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // apb
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cbz_pkg::reg_idx_t'(paddr[3:2]);

    always_comb begin
        case (cbz_pkg::reg_idx_t'(paddr[3:2]))
            cbz_pkg::REG_P1X: prdata = {15'b0, p1x_reg};
            cbz_pkg::REG_P1Y: prdata = 32'(p1y_reg);
            cbz_pkg::REG_P2X: prdata = {15'b0, p2x_reg};
            cbz_pkg::REG_P2Y: prdata = 32'(p2y_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1x_reg <= '0;
            p1y_reg <= '0;
            p2x_reg <= 17'(cbz_pkg::ONE_Q);
            p2y_reg <= 28'(cbz_pkg::ONE_Q);
        end else if (cfg_wr) begin
            case (cfg_idx)
                cbz_pkg::REG_P1X: p1x_reg <= pwdata[16:0];
                cbz_pkg::REG_P1Y: p1y_reg <= pwdata[27:0];
                cbz_pkg::REG_P2X: p2x_reg <= pwdata[16:0];
                cbz_pkg::REG_P2Y: p2y_reg <= pwdata[27:0];
                default: ;
            endcase
        end
    end

    // coefficients follow the registers
    assign p1x_c   = (p1x_reg > ONE_T) ? ONE_T : p1x_reg;
    assign p2x_c   = (p2x_reg > ONE_T) ? ONE_T : p2x_reg;
    assign cx_next = COEF_W'(3) * signed'(COEF_W'(p1x_c));
    assign bx_next = COEF_W'(3) * (signed'(COEF_W'(p2x_c)) - signed'(COEF_W'(p1x_c))) - cx_next;
    assign ax_next = signed'(COEF_W'(cbz_pkg::ONE_Q)) - cx_next - bx_next;
    assign cy_next = COEF_W'(3) * COEF_W'(p1y_reg);
    assign by_next = COEF_W'(3) * (COEF_W'(p2y_reg) - COEF_W'(p1y_reg)) - cy_next;
    assign ay_next = signed'(COEF_W'(cbz_pkg::ONE_Q)) - cy_next - by_next;

    // multiply and accumulate datapath
    assign a_sel      = ev_y_reg ? ACC_W'(ay_reg) : ACC_W'(ax_reg);
    assign b_sel      = ev_y_reg ? ACC_W'(by_reg) : ACC_W'(bx_reg);
    assign c_sel      = ev_y_reg ? ACC_W'(cy_reg) : ACC_W'(cx_reg);
    assign start_coef = ev_d_reg ? ((a_sel <<< 1) + a_sel) : a_sel;
    assign add0       = ev_d_reg ? (b_sel <<< 1) : b_sel;
    assign x_diff     = x_reg - prev_reg;

    always_comb begin
        if (state_reg == cbz_pkg::ST_INTM) begin
            mul_a   = signed'(ACC_W'({x_diff, {FB{1'b0}}}));
            mul_b   = signed'({1'b0, t1_reg - t0_reg});
            mul_add = '0;
        end else begin
            mul_a   = (ev_k_reg == 2'd0) ? start_coef : acc_reg;
            mul_b   = signed'({1'b0, t2_reg});
            case (ev_k_reg)
                2'd0:    mul_add = add0;
                2'd1:    mul_add = c_sel;
                default: mul_add = '0;
            endcase
        end
    end

    assign prod    = mul_a * mul_b;
    assign mul_sh  = prod[FB +: ACC_W];
    assign mul_res = mul_sh + mul_add;
    assign ev_last = ev_d_reg ? (ev_k_reg == 2'd1) : (ev_k_reg == 2'd2);

    // grid point i*ONE/(SAMPLE_COUNT-1) stepped as quotient and remainder
    assign rsum = {1'b0, gr_reg} + (RW+1)'(STEP_R);
    always_comb begin
        if (rsum >= (RW+1)'(SAMPLE_COUNT - 1)) begin
            gq_adv = gq_reg + T_W'(STEP_Q) + 1'b1;
            gr_adv = RW'(rsum - (RW+1)'(SAMPLE_COUNT - 1));
        end else begin
            gq_adv = gq_reg + T_W'(STEP_Q);
            gr_adv = RW'(rsum);
        end
    end

    assign s_x  = signed'(s_tdata);
    assign x_in = (s_x < 0) ? '0 : ((s_x > signed'(32'(cbz_pkg::ONE_Q))) ? ONE_T : s_x[T_W-1:0]);
    assign x_ext     = signed'(ACC_W'(x_reg));
    assign xres      = acc_reg - x_ext;
    assign q_w       = {div_rsp.quot[QW-1], div_rsp.quot};
    assign t0_w      = signed'((QW+1)'(t0_reg));
    assign t2_w      = signed'((QW+1)'(t2_reg));
    assign tbl_cur   = tbl_reg[i_reg];
    assign t_mid_lo  = (x_ext > acc_reg) ? t2_reg : t0_reg;
    assign t_mid_hi  = (x_ext > acc_reg) ? t1_reg : t2_reg;
    assign t_sum     = {1'b0, t_mid_lo} + {1'b0, t_mid_hi};
    assign acc_clamp = (acc_reg < 0) ? '0
                     : ((acc_reg > signed'(ACC_W'(cbz_pkg::ONE_Q))) ? ONE_T : acc_reg[T_W-1:0]);

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        ev_k_next     = ev_k_reg;
        ev_y_next     = ev_y_reg;
        ev_d_next     = ev_d_reg;
        acc_next      = acc_reg;
        x2_next       = x2_reg;
        dx_next       = dx_reg;
        i_next        = i_reg;
        gq_next       = gq_reg;
        gr_next       = gr_reg;
        gprev_next    = gprev_reg;
        x_next        = x_reg;
        prev_next     = prev_reg;
        span_next     = span_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        n_next        = n_reg;
        b_next        = b_reg;
        y_next        = y_reg;
        slope_next    = slope_reg;
        sat_next      = sat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        tbl_we        = 1'b0;
        tbl_wd        = acc_clamp;
        s_tready      = 1'b0;
        div_req       = '0;

        case (state_reg)
            cbz_pkg::ST_TINIT: begin
                i_next     = '0;
                gq_next    = '0;
                gr_next    = '0;
                t2_next    = '0;
                ev_k_next  = '0;
                ev_y_next  = 1'b0;
                ev_d_next  = 1'b0;
                ret_next   = cbz_pkg::ST_TWR;
                state_next = cbz_pkg::ST_EVAL;
            end
            cbz_pkg::ST_TWR: begin
                tbl_we = 1'b1;
                if (i_reg == IW'(SAMPLE_COUNT - 1)) begin
                    state_next = cbz_pkg::ST_IDLE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    gq_next    = gq_adv;
                    gr_next    = gr_adv;
                    t2_next    = gq_adv;
                    ev_k_next  = '0;
                    ev_y_next  = 1'b0;
                    ev_d_next  = 1'b0;
                    ret_next   = cbz_pkg::ST_TWR;
                    state_next = cbz_pkg::ST_EVAL;
                end
            end
            cbz_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next     = x_in;
                    i_next     = IW'(1);
                    gprev_next = '0;
                    gq_next    = T_W'(STEP_Q);
                    gr_next    = RW'(STEP_R);
                    t0_next    = '0;
                    t1_next    = ONE_T;
                    t2_next    = x_in;
                    prev_next  = tbl_reg[0];
                    state_next = cbz_pkg::ST_SRCH;
                end
            end
            cbz_pkg::ST_SRCH: begin
                if (x_reg <= tbl_cur) begin
                    t1_next   = gq_reg;
                    t0_next   = gprev_reg;
                    span_next = tbl_cur - prev_reg;
                    if (tbl_cur != prev_reg) begin
                        state_next = cbz_pkg::ST_INTM;
                    end else begin
                        t2_next    = gprev_reg;
                        n_next     = '0;
                        ev_k_next  = '0;
                        ev_y_next  = 1'b0;
                        ev_d_next  = 1'b0;
                        ret_next   = cbz_pkg::ST_NXR;
                        state_next = (cbz_pkg::NEWTON_STEPS != 0) ? cbz_pkg::ST_EVAL
                                                                   : cbz_pkg::ST_FIN;
                    end
                end else if (i_reg == IW'(SAMPLE_COUNT - 1)) begin
                    n_next     = '0;
                    ev_k_next  = '0;
                    ev_y_next  = 1'b0;
                    ev_d_next  = 1'b0;
                    ret_next   = cbz_pkg::ST_NXR;
                    state_next = (cbz_pkg::NEWTON_STEPS != 0) ? cbz_pkg::ST_EVAL
                                                               : cbz_pkg::ST_FIN;
                end else begin
                    prev_next  = tbl_cur;
                    gprev_next = gq_reg;
                    gq_next    = gq_adv;
                    gr_next    = gr_adv;
                    i_next     = i_reg + 1'b1;
                end
            end
            cbz_pkg::ST_INTM: begin
                acc_next   = mul_res;
                state_next = cbz_pkg::ST_INTD;
            end
            cbz_pkg::ST_INTD: begin
                div_req.start = 1'b1;
                div_req.num   = NW'(acc_reg);
                div_req.den   = DW'(span_reg);
                state_next    = cbz_pkg::ST_INTW;
            end
            cbz_pkg::ST_INTW: begin
                if (div_rsp.done) begin
                    t2_next    = cbz_pkg::clamp_t(t0_w + q_w);
                    n_next     = '0;
                    ev_k_next  = '0;
                    ev_y_next  = 1'b0;
                    ev_d_next  = 1'b0;
                    ret_next   = cbz_pkg::ST_NXR;
                    state_next = (cbz_pkg::NEWTON_STEPS != 0) ? cbz_pkg::ST_EVAL
                                                               : cbz_pkg::ST_FIN;
                end
            end
            cbz_pkg::ST_EVAL: begin
                acc_next  = mul_res;
                ev_k_next = ev_k_reg + 1'b1;
                if (ev_last) begin
                    state_next = ret_reg;
                end
            end
            cbz_pkg::ST_NXR: begin
                x2_next = xres;
                if (xres == 0) begin
                    state_next = cbz_pkg::ST_FIN;
                end else begin
                    ev_k_next  = '0;
                    ev_y_next  = 1'b0;
                    ev_d_next  = 1'b1;
                    ret_next   = cbz_pkg::ST_NDR;
                    state_next = cbz_pkg::ST_EVAL;
                end
            end
            cbz_pkg::ST_NDR: begin
                if (acc_reg == 0) begin
                    b_next     = '0;
                    state_next = cbz_pkg::ST_BIS;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'({x2_reg, {FB{1'b0}}});
                    div_req.den   = DW'(acc_reg);
                    state_next    = cbz_pkg::ST_NDW;
                end
            end
            cbz_pkg::ST_NDW: begin
                if (div_rsp.done) begin
                    t2_next = cbz_pkg::clamp_t(t2_w - q_w);
                    n_next  = n_reg + 1'b1;
                    if (n_reg == NS_W'(cbz_pkg::NEWTON_STEPS - 1)) begin
                        b_next     = '0;
                        state_next = cbz_pkg::ST_BIS;
                    end else begin
                        ev_k_next  = '0;
                        ev_y_next  = 1'b0;
                        ev_d_next  = 1'b0;
                        ret_next   = cbz_pkg::ST_NXR;
                        state_next = cbz_pkg::ST_EVAL;
                    end
                end
            end
            cbz_pkg::ST_BIS: begin
                if ((b_reg > BIS_W'(FB)) || !(t0_reg < t1_reg)) begin
                    state_next = cbz_pkg::ST_FIN;
                end else begin
                    ev_k_next  = '0;
                    ev_y_next  = 1'b0;
                    ev_d_next  = 1'b0;
                    ret_next   = cbz_pkg::ST_BISR;
                    state_next = cbz_pkg::ST_EVAL;
                end
            end
            cbz_pkg::ST_BISR: begin
                if (acc_reg == x_ext) begin
                    state_next = cbz_pkg::ST_FIN;
                end else begin
                    t0_next    = t_mid_lo;
                    t1_next    = t_mid_hi;
                    t2_next    = t_sum[T_W:1];
                    b_next     = b_reg + 1'b1;
                    state_next = cbz_pkg::ST_BIS;
                end
            end
            cbz_pkg::ST_FIN: begin
                ev_k_next  = '0;
                ev_y_next  = 1'b1;
                ev_d_next  = 1'b0;
                ret_next   = cbz_pkg::ST_FY;
                state_next = cbz_pkg::ST_EVAL;
            end
            cbz_pkg::ST_FY: begin
                y_next     = cbz_pkg::sat32(QW'(acc_reg));
                ev_k_next  = '0;
                ev_y_next  = 1'b0;
                ev_d_next  = 1'b1;
                ret_next   = cbz_pkg::ST_FDX;
                state_next = cbz_pkg::ST_EVAL;
            end
            cbz_pkg::ST_FDX: begin
                dx_next    = acc_reg;
                ev_k_next  = '0;
                ev_y_next  = 1'b1;
                ev_d_next  = 1'b1;
                ret_next   = cbz_pkg::ST_FDY;
                state_next = cbz_pkg::ST_EVAL;
            end
            cbz_pkg::ST_FDY: begin
                if (dx_reg == 0) begin
                    slope_next = '0;
                    sat_next   = 1'b0;
                    state_next = cbz_pkg::ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'({acc_reg, {FB{1'b0}}});
                    div_req.den   = DW'(dx_reg);
                    state_next    = cbz_pkg::ST_FW;
                end
            end
            cbz_pkg::ST_FW: begin
                if (div_rsp.done) begin
                    slope_next = cbz_pkg::sat32(div_rsp.quot);
                    sat_next   = cbz_pkg::sat_ovf(div_rsp.quot);
                    state_next = cbz_pkg::ST_OUT;
                end
            end
            cbz_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {slope_reg, y_reg};
                    m_tuser_next  = sat_reg;
                    state_next    = cbz_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbz_pkg::ST_TINIT;
            end
        endcase

        // any register write rebuilds the table
        if (cfg_wr) begin
            state_next = cbz_pkg::ST_TINIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cbz_pkg::ST_TINIT;
            ret_reg      <= cbz_pkg::ST_IDLE;
            ev_k_reg     <= '0;
            ev_y_reg     <= 1'b0;
            ev_d_reg     <= 1'b0;
            i_reg        <= '0;
            gq_reg       <= '0;
            gr_reg       <= '0;
            n_reg        <= '0;
            b_reg        <= '0;
            t2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            ev_k_reg     <= ev_k_next;
            ev_y_reg     <= ev_y_next;
            ev_d_reg     <= ev_d_next;
            i_reg        <= i_next;
            gq_reg       <= gq_next;
            gr_reg       <= gr_next;
            n_reg        <= n_next;
            b_reg        <= b_next;
            t2_reg       <= t2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ax_reg      <= ax_next;
        bx_reg      <= bx_next;
        cx_reg      <= cx_next;
        ay_reg      <= ay_next;
        by_reg      <= by_next;
        cy_reg      <= cy_next;
        acc_reg     <= acc_next;
        x2_reg      <= x2_next;
        dx_reg      <= dx_next;
        gprev_reg   <= gprev_next;
        x_reg       <= x_next;
        prev_reg    <= prev_next;
        span_reg    <= span_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        y_reg       <= y_next;
        slope_reg   <= slope_next;
        sat_reg     <= sat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (tbl_we) begin
            tbl_reg[i_reg] <= tbl_wd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready)
        else $error("input taken right after a register write");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000))
        else $error("saturated slope is not an extreme value");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_t_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        t2_reg <= ONE_T)
        else $error("curve parameter left the unit interval");

endmodule
`default_nettype wire

// ----- hw/rtl/cbz_div.sv -----
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module cbz_div (
    input  wire               aclk,
    input  wire               aresetn,
    input  cbz_pkg::div_req_t req,
    output cbz_pkg::div_rsp_t rsp
);

    localparam int NW = cbz_pkg::DIV_NW;
    localparam int DW = cbz_pkg::DIV_DW;
    localparam int QW = cbz_pkg::DIV_QW;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dmag_reg, dmag_next;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;

    assign num_mag = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    assign den_mag = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
    assign rem_sh  = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, dmag_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            neg_next  = req.num[NW-1] ^ req.den[DW-1];
            cnt_next  = CW'(NW);
            q_next    = num_mag;
            rem_next  = '0;
            dmag_next = den_mag;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? -signed'({1'b0, q_reg}) : signed'({1'b0, q_reg});

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for the cubic bezier timing curve evaluator
`default_nettype none
module tb;

    localparam int     SAMPLES    = cbz_pkg::SAMPLE_COUNT_DEF;
    localparam longint UNIT       = 64'sd1 << cbz_pkg::FRAC_BITS;
    localparam longint CYCLE_CAP  = 1_500_000;

    typedef struct {
        logic [31:0] y;
        logic [31:0] slope;
        logic        sat;
    } curve_point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [cbz_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cubic_bezier_timing_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the control points and derived curve
    longint ctl_x1, ctl_y1, ctl_x2, ctl_y2;
    longint coef[6];
    longint x_samples[SAMPLES];

    curve_point_t pending_points[$];
    int  error_count = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  configs_used = 0;
    bit  idling_on = 1'b1;
    longint cycle_count = 0;
    int  rx_stall = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint floor_q(longint v);
        return v >>> cbz_pkg::FRAC_BITS;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint curve_at(int base, longint t);
        return floor_q((floor_q((floor_q(coef[base] * t) + coef[base+1]) * t) + coef[base+2]) * t);
    endfunction

    function automatic longint slope_at(int base, longint t);
        return floor_q((floor_q(3 * coef[base] * t) + 2 * coef[base+1]) * t) + coef[base+2];
    endfunction

    function automatic void rebuild_curve();
        longint px1, px2, t;
        px1 = ctl_x1 > UNIT ? UNIT : ctl_x1;
        px2 = ctl_x2 > UNIT ? UNIT : ctl_x2;
        coef[2] = 3 * px1;
        coef[1] = 3 * (px2 - px1) - coef[2];
        coef[0] = UNIT - coef[2] - coef[1];
        coef[5] = 3 * ctl_y1;
        coef[4] = 3 * (ctl_y2 - ctl_y1) - coef[5];
        coef[3] = UNIT - coef[5] - coef[4];
        for (int i = 0; i < SAMPLES; i++) begin
            t = longint'(i) * UNIT / (SAMPLES - 1);
            x_samples[i] = clampl(curve_at(0, t), 0, UNIT);
        end
    endfunction

    function automatic longint solve_param(longint x);
        longint lo, hi, t, r, d, xv, span;
        lo = 0; hi = UNIT; t = x; r = 0;
        for (int i = 1; i < SAMPLES; i++) begin
            if (x <= x_samples[i]) begin
                span = x_samples[i] - x_samples[i-1];
                hi = longint'(i) * UNIT / (SAMPLES - 1);
                lo = longint'(i - 1) * UNIT / (SAMPLES - 1);
                t = span != 0 ? lo + (hi - lo) * (x - x_samples[i-1]) / span : lo;
                t = clampl(t, 0, UNIT);
                break;
            end
        end
        for (int i = 0; i < cbz_pkg::NEWTON_STEPS; i++) begin
            r = curve_at(0, t) - x;
            if (r == 0) return t;
            d = slope_at(0, t);
            if (d == 0) break;
            t = clampl(t - (r * UNIT) / d, 0, UNIT);
        end
        if (r == 0) return t;
        for (int i = 0; i <= cbz_pkg::FRAC_BITS && lo < hi; i++) begin
            xv = curve_at(0, t);
            if (xv == x) return t;
            if (x > xv) lo = t;
            else hi = t;
            t = (lo + hi) >>> 1;
        end
        return t;
    endfunction

    function automatic curve_point_t predict_point(logic [31:0] raw);
        curve_point_t p;
        longint x, t, y, dx, dy, s;
        x = clampl(longint'(signed'(raw)), 0, UNIT);
        t = solve_param(x);
        y = clampl(curve_at(3, t), cbz_pkg::I32_MIN_L, cbz_pkg::I32_MAX_L);
        dx = slope_at(0, t);
        dy = slope_at(3, t);
        s = 0;
        p.sat = 1'b0;
        if (dx != 0) begin
            s = (dy * UNIT) / dx;
            if (s > cbz_pkg::I32_MAX_L || s < cbz_pkg::I32_MIN_L) begin
                s = clampl(s, cbz_pkg::I32_MIN_L, cbz_pkg::I32_MAX_L);
                p.sat = 1'b1;
            end
        end
        p.y = y[31:0];
        p.slope = s[31:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got, want);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        curve_point_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[31:0], '0);
            end else begin
                w = pending_points.pop_front();
                if (m_tdata[31:0] !== w.y) report_mismatch("curve_y", m_tdata[31:0], w.y);
                if (m_tdata[63:32] !== w.slope)
                    report_mismatch("curve_slope", m_tdata[63:32], w.slope);
                if (m_tuser[0] !== w.sat)
                    report_mismatch("slope_saturated", {31'b0, m_tuser[0]}, {31'b0, w.sat});
            end
            beats_checked++;
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (!idling_on) begin
            m_tready = 1'b1;
            rx_stall = 0;
        end else if (rx_stall > 0) begin
            m_tready = 1'b0;
            rx_stall--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready = 1'b0;
            rx_stall = $urandom_range(0, 10);
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic send_x(logic [31:0] x);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_points.push_back(predict_point(x));
        beats_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic apb_write(cbz_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = cbz_pkg::APB_AW'({idx, 2'b00});
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_curve(longint x1, longint y1, longint x2, longint y2);
        wait_drained();
        apb_write(cbz_pkg::REG_P1X, 32'(x1) & 32'h1ffff);
        apb_write(cbz_pkg::REG_P1Y, 32'(y1) & 32'h0fff_ffff);
        apb_write(cbz_pkg::REG_P2X, 32'(x2) & 32'h1ffff);
        apb_write(cbz_pkg::REG_P2Y, 32'(y2) & 32'h0fff_ffff);
        ctl_x1 = x1 & 64'h1ffff;
        ctl_y1 = y1;
        ctl_x2 = x2 & 64'h1ffff;
        ctl_y2 = y2;
        rebuild_curve();
        configs_used++;
        while (!s_tready) @(negedge aclk);
    endtask

    function automatic longint rand_y();
        return longint'($urandom_range(0, 1 << 27)) - (64'sd1 << 26);
    endfunction

    function automatic logic [31:0] rand_query();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(0, 65536);
        if (pick == 7) return x_samples[$urandom_range(0, SAMPLES - 1)][31:0];
        return $urandom;
    endfunction

    task automatic test_reset_curve();
        send_x(32'h0000_0000);
        send_x(32'h0001_0000);
        send_x(32'h0000_8000);
        send_x(32'h8000_0000);
        send_x(32'h7fff_ffff);
        send_x(32'hffff_ffff);
        send_x(32'h0000_0001);
        send_x(32'h0000_ffff);
    endtask

    task automatic test_extreme_points();
        // ease with flat ends, dx is zero at the start point
        set_curve(0, 0, 0, 65536);
        send_x(32'h0000_0000); send_x(32'h0001_0000); send_x(32'h0000_4000);
        // inner x at one and beyond one, saturated back to one
        set_curve(65536, 1 << 26, 131071, -(64'sd1 << 26));
        send_x(32'h0000_0000); send_x(32'h0001_0000); send_x(32'h0000_c000);
        send_x(32'h0000_3000);
        // steep rise gives a saturated slope
        set_curve(65536, 1 << 26, 65536, 1 << 26);
        send_x(32'h0000_0001); send_x(32'h0000_ff00); send_x(32'h0000_8000);
        // narrow table spans, dx is zero in the middle
        set_curve(65536, -(64'sd1 << 26), 0, 1 << 26);
        send_x(32'h0000_8000); send_x(x_samples[5][31:0]); send_x(32'h0000_7fff);
        send_x(32'h0001_0001); send_x(32'hfff0_0000);
    endtask

    task automatic test_random_curves();
        for (int c = 0; c < 6; c++) begin
            if (c == 5) idling_on = 1'b0;
            set_curve($urandom_range(0, 9) == 0 ? $urandom_range(65536, 131071)
                                                 : $urandom_range(0, 65536),
                      rand_y(), $urandom_range(0, 65536), rand_y());
            for (int i = 0; i < 100; i++) send_x(rand_query());
        end
    endtask

    initial begin
        int waited;
        ctl_x1 = 0; ctl_y1 = 0; ctl_x2 = UNIT; ctl_y2 = UNIT;
        rebuild_curve();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_curve();
        test_extreme_points();
        test_random_curves();
        waited = 0;
        while (pending_points.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (700) @(negedge aclk);
        $display("sent %0d queries over %0d control point settings, checked %0d results",
                 beats_sent, configs_used + 1, beats_checked);
        if (error_count == 0 && pending_points.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count, pending_points.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
